// ===== hw/rtl/trnh_pkg.sv =====
package trnh_pkg;

  // default widths of tree addresses and depths
  localparam int DEF_ADDR_BITS  = 16;
  localparam int DEF_DEPTH_BITS = 4;

  // child and router counts
  localparam int COUNT_W = 8;

  // block size arithmetic, saturating at 2^40
  localparam int                  CSKIP_W   = 41;
  localparam logic [CSKIP_W-1:0]  CSKIP_CAP = {1'b1, {(CSKIP_W-1){1'b0}}};

  // configuration register indexes
  localparam int                  CFG_IDX_W         = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHILDREN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUTERS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_DEPTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_ADDR  = 3'd5;

  // configuration reset values
  localparam int RST_MAX_DEPTH    = 5;
  localparam int RST_MAX_CHILDREN = 4;
  localparam int RST_MAX_ROUTERS  = 4;

  // routing actions
  typedef enum logic [1:0] {
    ACT_DELIVER   = 2'd0,
    ACT_FORWARD   = 2'd1,
    ACT_DROP_LOOP = 2'd2,
    ACT_DROP_TTL  = 2'd3
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAR_SUM,
    S_PAR_CHK,
    S_KID_SUM,
    S_KID_CHK,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/trnh_sat_mac.sv =====
module trnh_sat_mac (
  input  logic [trnh_pkg::CSKIP_W-1:0] acc,
  input  logic [trnh_pkg::COUNT_W-1:0] mult,
  output logic [trnh_pkg::CSKIP_W-1:0] res
);

  localparam int PW = trnh_pkg::CSKIP_W + trnh_pkg::COUNT_W;

  logic [PW-1:0] prod;

  // acc * mult + 1, clipped at the block size cap
  assign prod = {{trnh_pkg::COUNT_W{1'b0}}, acc} * {{trnh_pkg::CSKIP_W{1'b0}}, mult}
              + PW'(1);
  assign res  = (prod > PW'(trnh_pkg::CSKIP_CAP)) ? trnh_pkg::CSKIP_CAP
                                                  : prod[trnh_pkg::CSKIP_W-1:0];

endmodule

// ===== hw/rtl/tree_route_next_hop.sv =====
// Tree routing next-hop decision, one packet at a time.
// Input channel (in_valid/in_ready) carries one packet description per item;
// the result channel (out_valid/out_ready) returns one routing decision per item.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, one register per
// cycle; the user must write it only while no packet is in flight, since the block
// itself does not enforce this. Drops, deliveries and broadcasts go from accept
// straight to S_DONE and on into the output register. Unicast forwarding computes
// the address block size on one shared saturating multiply-add unit, one step per
// cycle: first, where needed, the parent block (S_PAR_SUM) and its check
// (S_PAR_CHK), then the own block (S_KID_SUM, S_KID_CHK), then a bit-serial
// restoring remainder (S_DIV) and the hand-over (S_DONE); the sequencer then
// returns to S_IDLE before the next item is accepted.
// in_ready is high only while the sequencer is idle, so one item is worked at a
// time. A finished result moves into the output register; while the receiver
// stalls it is held there and the next item may already be accepted and worked.
// A further result waits in the sequencer until the output register frees up.
// Reset (rst_n low at a clock edge) empties the block and restores the
// configuration defaults: max_depth 5, max_children 4, max_routers 4, addresses
// and own_depth 0.
module tree_route_next_hop #(
  parameter int ADDR_BITS  = trnh_pkg::DEF_ADDR_BITS,
  parameter int DEPTH_BITS = trnh_pkg::DEF_DEPTH_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [trnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_BITS-1:0]            cfg_wdata,
  // packet in
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ADDR_BITS-1:0]            in_dest_address,
  input  logic [7:0]                      in_ttl_in,
  input  logic                            in_from_self,
  input  logic                            in_forwarded_before,
  input  logic                            in_going_up,
  input  logic                            in_dest_broadcast,
  // decision out
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_action,
  output logic [ADDR_BITS-1:0]            out_hop_addr,
  output logic                            out_hop_broadcast,
  output logic [7:0]                      out_ttl_out,
  output logic                            out_add_ip_header
);

  localparam int CW   = trnh_pkg::CSKIP_W;
  localparam int NW   = trnh_pkg::COUNT_W;
  localparam int BC_W = $clog2(ADDR_BITS);

  // configuration registers
  logic [DEPTH_BITS-1:0] max_depth_r;
  logic [NW-1:0]         max_children_r;
  logic [NW-1:0]         max_routers_r;
  logic [ADDR_BITS-1:0]  own_address_r;
  logic [DEPTH_BITS-1:0] own_depth_r;
  logic [ADDR_BITS-1:0]  parent_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r      <= DEPTH_BITS'(trnh_pkg::RST_MAX_DEPTH);
      max_children_r   <= NW'(trnh_pkg::RST_MAX_CHILDREN);
      max_routers_r    <= NW'(trnh_pkg::RST_MAX_ROUTERS);
      own_address_r    <= '0;
      own_depth_r      <= '0;
      parent_address_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        trnh_pkg::CFG_MAX_DEPTH:    max_depth_r      <= cfg_wdata[DEPTH_BITS-1:0];
        trnh_pkg::CFG_MAX_CHILDREN: max_children_r   <= cfg_wdata[NW-1:0];
        trnh_pkg::CFG_MAX_ROUTERS:  max_routers_r    <= cfg_wdata[NW-1:0];
        trnh_pkg::CFG_OWN_ADDRESS:  own_address_r    <= cfg_wdata;
        trnh_pkg::CFG_OWN_DEPTH:    own_depth_r      <= cfg_wdata[DEPTH_BITS-1:0];
        trnh_pkg::CFG_PARENT_ADDR:  parent_address_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and work registers
  trnh_pkg::state_t       state_r, state_nxt;
  logic [CW-1:0]          acc_r, acc_nxt;
  logic [DEPTH_BITS-1:0]  cnt_r, cnt_nxt;
  logic [BC_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [ADDR_BITS-1:0]   x_r, x_nxt;
  logic [ADDR_BITS-1:0]   rem_r, rem_nxt;
  logic [ADDR_BITS-1:0]   dest_r, dest_nxt;
  logic [1:0]             act_r, act_nxt;
  logic [ADDR_BITS-1:0]   hop_r, hop_nxt;
  logic                   hopb_r, hopb_nxt;
  logic [7:0]             ttl_r, ttl_nxt;
  logic                   hdr_r, hdr_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_action_r, out_action_nxt;
  logic [ADDR_BITS-1:0]   out_hop_r, out_hop_nxt;
  logic                   out_hopb_r, out_hopb_nxt;
  logic [7:0]             out_ttl_r, out_ttl_nxt;
  logic                   out_hdr_r, out_hdr_nxt;

  // shared saturating multiply-add
  logic [NW-1:0] mac_mult;
  logic [CW-1:0] mac_res;

  assign mac_mult = (cnt_r != '0) ? max_routers_r : max_children_r;

  trnh_sat_mac u_mac (
    .acc  (acc_r),
    .mult (mac_mult),
    .res  (mac_res)
  );

  // packet classification on the input fields
  logic       in_loop;
  logic [7:0] in_ttl_dec;
  logic       in_deliver;
  logic       in_unicast;

  assign in_loop    = in_from_self & in_forwarded_before;
  assign in_ttl_dec = (in_ttl_in == 8'd0) ? 8'd0 : in_ttl_in - 8'd1;
  assign in_deliver = in_going_up & (in_dest_broadcast | (in_dest_address == own_address_r));
  assign in_unicast = !in_loop && (in_ttl_dec != 8'd0) && !in_deliver && !in_dest_broadcast;

  // block size set-up for own block and parent block
  logic                  kid_none, par_none;
  logic [DEPTH_BITS-1:0] kid_cnt, par_cnt;

  assign kid_none = own_depth_r >= max_depth_r;
  assign par_none = own_depth_r > max_depth_r;
  assign kid_cnt  = max_depth_r - own_depth_r - DEPTH_BITS'(1);
  assign par_cnt  = max_depth_r - own_depth_r;

  // destination checks against the block sizes
  logic [ADDR_BITS:0]   first_addr;
  logic                 in_par_block;
  logic [ADDR_BITS:0]   rem_sh;
  logic [CW-1:0]        rem_diff;
  logic                 rem_ge;

  assign first_addr   = {1'b0, own_address_r} + (ADDR_BITS+1)'(1);
  assign in_par_block = (dest_r > own_address_r) &&
                        (CW'(dest_r - own_address_r) < acc_r);
  assign rem_sh       = {rem_r, x_r[ADDR_BITS-1]};
  assign rem_diff     = CW'(rem_sh) - acc_r;
  assign rem_ge       = CW'(rem_sh) >= acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trnh_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    cnt_r        <= cnt_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    x_r          <= x_nxt;
    rem_r        <= rem_nxt;
    dest_r       <= dest_nxt;
    act_r        <= act_nxt;
    hop_r        <= hop_nxt;
    hopb_r       <= hopb_nxt;
    ttl_r        <= ttl_nxt;
    hdr_r        <= hdr_nxt;
    out_action_r <= out_action_nxt;
    out_hop_r    <= out_hop_nxt;
    out_hopb_r   <= out_hopb_nxt;
    out_ttl_r    <= out_ttl_nxt;
    out_hdr_r    <= out_hdr_nxt;
  end

  // next state and work register updates
  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    x_nxt          = x_r;
    rem_nxt        = rem_r;
    dest_nxt       = dest_r;
    act_nxt        = act_r;
    hop_nxt        = hop_r;
    hopb_nxt       = hopb_r;
    ttl_nxt        = ttl_r;
    hdr_nxt        = hdr_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_action_nxt = out_action_r;
    out_hop_nxt    = out_hop_r;
    out_hopb_nxt   = out_hopb_r;
    out_ttl_nxt    = out_ttl_r;
    out_hdr_nxt    = out_hdr_r;
    in_ready       = 1'b0;

    case (state_r)
      trnh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dest_nxt = in_dest_address;
          hop_nxt  = '0;
          hopb_nxt = 1'b0;
          acc_nxt  = '0;
          if (in_loop) begin
            act_nxt = trnh_pkg::ACT_DROP_LOOP;
            ttl_nxt = in_ttl_in;
            hdr_nxt = 1'b0;
          end else begin
            ttl_nxt = in_ttl_dec;
            hdr_nxt = in_from_self;
            if (in_ttl_dec == 8'd0) begin
              act_nxt = trnh_pkg::ACT_DROP_TTL;
            end else if (in_deliver) begin
              act_nxt = trnh_pkg::ACT_DELIVER;
            end else begin
              act_nxt  = trnh_pkg::ACT_FORWARD;
              hopb_nxt = in_dest_broadcast;
            end
          end
          if (!in_unicast) begin
            state_nxt = trnh_pkg::S_DONE;
          end else if (own_address_r == '0) begin
            if (kid_none) begin
              hop_nxt   = parent_address_r;
              state_nxt = trnh_pkg::S_DONE;
            end else begin
              cnt_nxt   = kid_cnt;
              state_nxt = trnh_pkg::S_KID_SUM;
            end
          end else if (par_none) begin
            hop_nxt   = parent_address_r;
            state_nxt = trnh_pkg::S_DONE;
          end else begin
            cnt_nxt   = par_cnt;
            state_nxt = trnh_pkg::S_PAR_SUM;
          end
        end
      end

      // parent block size, one multiply-add per cycle
      trnh_pkg::S_PAR_SUM: begin
        acc_nxt = mac_res;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - DEPTH_BITS'(1);
        end else begin
          state_nxt = trnh_pkg::S_PAR_CHK;
        end
      end

      // destination inside the parent's block goes down, else up; always up when no child level is left
      trnh_pkg::S_PAR_CHK: begin
        acc_nxt = '0;
        if (!in_par_block || kid_none) begin
          hop_nxt   = parent_address_r;
          state_nxt = trnh_pkg::S_DONE;
        end else begin
          cnt_nxt   = kid_cnt;
          state_nxt = trnh_pkg::S_KID_SUM;
        end
      end

      // own block size
      trnh_pkg::S_KID_SUM: begin
        acc_nxt = mac_res;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - DEPTH_BITS'(1);
        end else begin
          state_nxt = trnh_pkg::S_KID_CHK;
        end
      end

      // below the first child block, or start the remainder
      trnh_pkg::S_KID_CHK: begin
        if ({1'b0, dest_r} < first_addr) begin
          hop_nxt   = first_addr[ADDR_BITS-1:0];
          state_nxt = trnh_pkg::S_DONE;
        end else begin
          x_nxt       = dest_r - first_addr[ADDR_BITS-1:0];
          rem_nxt     = '0;
          bit_cnt_nxt = BC_W'(ADDR_BITS - 1);
          state_nxt   = trnh_pkg::S_DIV;
        end
      end

      // restoring remainder by the block size, one bit per cycle
      trnh_pkg::S_DIV: begin
        x_nxt   = x_r << 1;
        rem_nxt = rem_ge ? rem_diff[ADDR_BITS-1:0] : rem_sh[ADDR_BITS-1:0];
        if (bit_cnt_r == '0) begin
          hop_nxt   = dest_r - rem_nxt;
          state_nxt = trnh_pkg::S_DONE;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BC_W'(1);
        end
      end

      // hand the decision to the output register
      trnh_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = act_r;
          out_hop_nxt    = hop_r;
          out_hopb_nxt   = hopb_r;
          out_ttl_nxt    = ttl_r;
          out_hdr_nxt    = hdr_r;
          state_nxt      = trnh_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = trnh_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_hop_addr      = out_hop_r;
  assign out_hop_broadcast = out_hopb_r;
  assign out_ttl_out       = out_ttl_r;
  assign out_add_ip_header = out_hdr_r;

`ifndef SYNTHESIS
  // broadcast hop only on a forward
  a_bcast_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hop_broadcast |-> out_action == trnh_pkg::ACT_FORWARD)
    else $error("broadcast hop without forward");

  // unicast hop is zero unless forwarding
  a_hop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != trnh_pkg::ACT_FORWARD |-> out_hop_addr == '0 &&
    !out_hop_broadcast)
    else $error("next hop set on a non-forward item");

  // a loop drop never reports an added header
  a_loop_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == trnh_pkg::ACT_DROP_LOOP |-> !out_add_ip_header)
    else $error("header flag on loop drop");

  // remainder stays below the block size
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trnh_pkg::S_DIV |-> CW'(rem_r) < acc_r)
    else $error("remainder not below divisor");

  // own block size never zero when dividing
  a_cskip_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trnh_pkg::S_KID_CHK |-> acc_r != '0)
    else $error("zero block size");
`endif

endmodule
